// ===== hw/rtl/nacc_pkg.sv =====
package nacc_pkg;

  localparam logic [7:0] OpDeleteSq   = 8'h00;
  localparam logic [7:0] OpCreateSq   = 8'h01;
  localparam logic [7:0] OpGetLog     = 8'h02;
  localparam logic [7:0] OpDeleteCq   = 8'h04;
  localparam logic [7:0] OpCreateCq   = 8'h05;
  localparam logic [7:0] OpIdentify   = 8'h06;
  localparam logic [7:0] OpSetFeat    = 8'h09;
  localparam logic [7:0] OpAsyncEvent = 8'h0C;

  localparam logic [7:0] FeatNumQueues = 8'h07;

  localparam logic [1:0] StatusSuccess      = 2'd0;
  localparam logic [1:0] StatusInvalidField = 2'd1;
  localparam logic [1:0] StatusAsyncLimit   = 2'd2;

  localparam int unsigned SlotWidth  = 12;
  localparam int unsigned DepthWidth = 13;
  localparam logic [DepthWidth-1:0] DepthReset = 13'd32;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef struct packed {
    logic [7:0]           opcode;
    logic [15:0]          cmd_ident;
    logic [SlotWidth-1:0] sq_slot;
    logic [7:0]           identify_type;
    logic [7:0]           feature_id;
    logic [31:0]          dword_eleven;
  } in_item_t;

  typedef struct packed {
    logic [SlotWidth-1:0] cq_slot;
    logic                 entry_written;
    logic [15:0]          done_command_id;
    logic [SlotWidth-1:0] sq_head;
    logic [1:0]           status;
    logic                 phase;
    logic                 result_written;
    logic [31:0]          result;
  } out_item_t;

  typedef struct packed {
    logic                 entry_written;
    logic [15:0]          cmd_ident;
    logic [SlotWidth-1:0] sq_head;
    logic [1:0]           status;
    logic                 result_written;
    logic [31:0]          result;
  } cmd_t;

endpackage

// ===== hw/rtl/nacc_front.sv =====
module nacc_front #(
  parameter int unsigned MaxIoQueues = 64
) (
  input  nacc_pkg::in_item_t item_i,
  output nacc_pkg::cmd_t     cmd_o
);

  localparam logic [15:0] MaxZeroBased = 16'(MaxIoQueues - 1);

  logic [15:0] sq_grant;
  logic [15:0] cq_grant;
  logic        written;
  logic [1:0]  status;
  logic        res_written;
  logic [31:0] result;

  assign sq_grant = (item_i.dword_eleven[15:0] > MaxZeroBased) ? MaxZeroBased
                                                               : item_i.dword_eleven[15:0];
  assign cq_grant = (item_i.dword_eleven[31:16] > MaxZeroBased) ? MaxZeroBased
                                                                : item_i.dword_eleven[31:16];

  always_comb begin
    written     = 1'b1;
    status      = nacc_pkg::StatusSuccess;
    res_written = 1'b0;
    result      = 32'd0;
    unique case (item_i.opcode)
      nacc_pkg::OpDeleteSq, nacc_pkg::OpCreateSq, nacc_pkg::OpDeleteCq,
      nacc_pkg::OpCreateCq, nacc_pkg::OpIdentify: begin
        status = nacc_pkg::StatusSuccess;
      end
      nacc_pkg::OpGetLog: begin
        status = nacc_pkg::StatusInvalidField;
      end
      nacc_pkg::OpSetFeat: begin
        if (item_i.feature_id == nacc_pkg::FeatNumQueues) begin
          res_written = 1'b1;
          result      = {cq_grant, sq_grant};
        end
      end
      nacc_pkg::OpAsyncEvent: begin
        status      = nacc_pkg::StatusAsyncLimit;
        res_written = 1'b1;
      end
      default: begin
        written = 1'b0;
      end
    endcase
  end

  assign cmd_o.entry_written  = written;
  assign cmd_o.cmd_ident      = written ? item_i.cmd_ident : 16'd0;
  assign cmd_o.sq_head        = written ? item_i.sq_slot : '0;
  assign cmd_o.status         = written ? status : nacc_pkg::StatusSuccess;
  assign cmd_o.result_written = res_written;
  assign cmd_o.result         = result;

endmodule

// ===== hw/rtl/nacc_queue.sv =====
module nacc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nacc_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output nacc_pkg::cmd_t pop_data_o
);

  nacc_pkg::cmd_t mem_q [nacc_pkg::QueueDepth];

  logic [nacc_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [nacc_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [nacc_pkg::QueueCntW-1:0] count_q, count_d;

  assign full_o     = (count_q == nacc_pkg::QueueCntW'(nacc_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/nacc_back.sv =====
module nacc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [nacc_pkg::DepthWidth-1:0]     cfg_data_i,
  input  logic                                empty_i,
  input  nacc_pkg::cmd_t                      cmd_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output nacc_pkg::out_item_t                 out_data_o
);

  logic [nacc_pkg::DepthWidth-1:0] depth_q, depth_d;
  logic [nacc_pkg::SlotWidth-1:0]  head_q, head_d;
  logic                            phase_q, phase_d;
  logic                            valid_q, valid_d;
  nacc_pkg::out_item_t             data_q, data_d;
  logic [nacc_pkg::DepthWidth-1:0] head_inc;
  logic                            wrap;

  assign pop_o    = !empty_i && (!valid_q || !out_stall_i);
  assign head_inc = {1'b0, head_q} + 1'b1;
  assign wrap     = (head_inc >= depth_q) || head_inc[nacc_pkg::DepthWidth-1];

  always_comb begin
    depth_d = cfg_valid_i ? cfg_data_i : depth_q;
    head_d  = head_q;
    phase_d = phase_q;
    valid_d = valid_q && out_stall_i;
    data_d  = data_q;
    if (pop_o) begin
      valid_d                = 1'b1;
      data_d.cq_slot         = head_q;
      data_d.entry_written   = cmd_i.entry_written;
      data_d.done_command_id = cmd_i.cmd_ident;
      data_d.sq_head         = cmd_i.sq_head;
      data_d.status          = cmd_i.status;
      data_d.phase           = cmd_i.entry_written & phase_q;
      data_d.result_written  = cmd_i.result_written;
      data_d.result          = cmd_i.result;
      if (wrap) begin
        head_d  = '0;
        phase_d = !phase_q;
      end else begin
        head_d = head_inc[nacc_pkg::SlotWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= nacc_pkg::DepthReset;
      head_q  <= '0;
      phase_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/nvme_admin_command_completer.sv =====
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out       source     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_data_i (completion depth)
//
// One command per cycle sustained while the output is not stalled; a command is presented at the
// output after its transfer (decode into a two-entry queue, then the completion slot register).
// The completion head and phase advance when a command leaves the queue.
// Reset clears the head to 0, sets the phase to 1 and the depth to 32.
// A stalled output holds its entry; the queue absorbs up to two more commands.
module nvme_admin_command_completer #(
  parameter int unsigned MaxIoQueues = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nacc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nacc_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nacc_pkg::DepthWidth-1:0] cfg_data_i
);

  nacc_pkg::cmd_t front_cmd;
  nacc_pkg::cmd_t queue_cmd;
  logic           full;
  logic           empty;
  logic           push;
  logic           pop;

  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  nacc_front #(
    .MaxIoQueues(MaxIoQueues)
  ) u_front (
    .item_i(in_data_i),
    .cmd_o (front_cmd)
  );

  nacc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (queue_cmd)
  );

  nacc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (empty),
    .cmd_i      (queue_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned IoQueueLimit = 64;
  localparam int unsigned CycleLimit   = 300000;
  localparam logic [7:0]  OpAbort      = 8'h08;
  localparam logic [7:0]  OpGetFeat    = 8'h0A;
  localparam logic [7:0]  FeatOther    = 8'h06;

  class completion_board;
    nacc_pkg::out_item_t                       expected_entries[$];
    logic [nacc_pkg::DepthWidth-1:0] depth = nacc_pkg::DepthReset;
    logic [nacc_pkg::SlotWidth-1:0]  head  = '0;
    logic                            phase = 1'b1;
    logic [16:0]                     granted_sq = '0;
    logic [16:0]                     granted_cq = '0;
    int unsigned                     bad_count = 0;

    function logic [16:0] clamp_queues(logic [15:0] zero_based);
      logic [16:0] n;
      n = {1'b0, zero_based} + 17'd1;
      return (n > IoQueueLimit) ? 17'(IoQueueLimit) : n;
    endfunction

    function void note_command(nacc_pkg::in_item_t c);
      nacc_pkg::out_item_t e;
      logic [12:0]         nxt;
      e = '0;
      e.cq_slot         = head;
      e.entry_written   = 1'b1;
      e.done_command_id = c.cmd_ident;
      e.sq_head         = c.sq_slot;
      e.phase           = phase;
      e.status          = nacc_pkg::StatusSuccess;
      case (c.opcode)
        nacc_pkg::OpDeleteSq, nacc_pkg::OpCreateSq, nacc_pkg::OpDeleteCq,
        nacc_pkg::OpCreateCq, nacc_pkg::OpIdentify: ;
        nacc_pkg::OpGetLog: e.status = nacc_pkg::StatusInvalidField;
        nacc_pkg::OpSetFeat: begin
          if (c.feature_id == nacc_pkg::FeatNumQueues) begin
            granted_sq = clamp_queues(c.dword_eleven[15:0]);
            granted_cq = clamp_queues(c.dword_eleven[31:16]);
            e.result_written = 1'b1;
            e.result = {16'(granted_cq - 17'd1), 16'(granted_sq - 17'd1)};
          end
        end
        nacc_pkg::OpAsyncEvent: begin
          e.status         = nacc_pkg::StatusAsyncLimit;
          e.result_written = 1'b1;
          e.result         = '0;
        end
        default: begin
          e = '0;
          e.cq_slot = head;
        end
      endcase
      nxt = {1'b0, head} + 13'd1;
      if (nxt >= depth || nxt >= 13'd4096) begin
        head  = '0;
        phase = ~phase;
      end else begin
        head = nxt[nacc_pkg::SlotWidth-1:0];
      end
      expected_entries.push_back(e);
    endfunction

    function void check_completion(nacc_pkg::out_item_t got);
      nacc_pkg::out_item_t e;
      if (expected_entries.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected completion: slot=%h cid=%h", got.cq_slot,
                   got.done_command_id);
        return;
      end
      e = expected_entries.pop_front();
      if (got.cq_slot !== e.cq_slot || got.entry_written !== e.entry_written ||
          got.done_command_id !== e.done_command_id || got.sq_head !== e.sq_head ||
          got.status !== e.status || got.phase !== e.phase ||
          got.result_written !== e.result_written || got.result !== e.result) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("completion mismatch: expected slot=%h wr=%b cid=%h head=%h st=%h %s",
                   e.cq_slot, e.entry_written, e.done_command_id, e.sq_head, e.status,
                   $sformatf("ph=%b rw=%b res=%h", e.phase, e.result_written, e.result));
          $display("                       actual slot=%h wr=%b cid=%h head=%h st=%h %s",
                   got.cq_slot, got.entry_written, got.done_command_id, got.sq_head,
                   got.status,
                   $sformatf("ph=%b rw=%b res=%h", got.phase, got.result_written,
                             got.result));
        end
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  nacc_pkg::in_item_t              in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  nacc_pkg::out_item_t             out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [nacc_pkg::DepthWidth-1:0] cfg_data_i  = '0;

  completion_board sb = new();
  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  int unsigned     cycle_count = 0;
  int unsigned     phase_depth[6];
  int unsigned     phase_items[6];

  nvme_admin_command_completer #(
    .MaxIoQueues(IoQueueLimit)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_completion(out_data_o);
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic nacc_pkg::in_item_t build_command(logic [7:0] op, logic [15:0] cid,
                                                       logic [11:0] slot, logic [7:0] cns,
                                                       logic [7:0] fid, logic [31:0] dw);
    nacc_pkg::in_item_t c;
    c.opcode        = op;
    c.cmd_ident     = cid;
    c.sq_slot       = slot;
    c.identify_type = cns;
    c.feature_id    = fid;
    c.dword_eleven  = dw;
    return c;
  endfunction

  function automatic logic [15:0] queue_request();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(0, 70));
      1:       return 16'($urandom_range(60, 68));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic nacc_pkg::in_item_t random_command();
    logic [7:0] op;
    logic [7:0] fid;
    case ($urandom_range(0, 13))
      0:  op = nacc_pkg::OpDeleteSq;
      1:  op = nacc_pkg::OpCreateSq;
      2:  op = nacc_pkg::OpGetLog;
      3:  op = nacc_pkg::OpDeleteCq;
      4:  op = nacc_pkg::OpCreateCq;
      5:  op = nacc_pkg::OpIdentify;
      6:  op = nacc_pkg::OpSetFeat;
      7:  op = nacc_pkg::OpSetFeat;
      8:  op = nacc_pkg::OpSetFeat;
      9:  op = nacc_pkg::OpAsyncEvent;
      10: op = OpAbort;
      11: op = OpGetFeat;
      default: op = 8'($urandom_range(0, 255));
    endcase
    fid = ($urandom_range(0, 9) < 7) ? nacc_pkg::FeatNumQueues : 8'($urandom_range(0, 255));
    return build_command(op, 16'($urandom), 12'($urandom), 8'($urandom), fid,
                         {queue_request(), queue_request()});
  endfunction

  task automatic send_command(nacc_pkg::in_item_t c);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c);
  endtask

  task automatic write_depth(logic [nacc_pkg::DepthWidth-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.depth = d;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_entries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 86; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 86; end
      default: begin idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  initial begin
    phase_depth[0] = 4096;
    phase_depth[1] = 3;
    phase_depth[2] = 4095;
    phase_depth[3] = $urandom_range(2, 64);
    phase_depth[4] = 2;
    phase_depth[5] = $urandom_range(2, 4096);
    phase_items[0] = 160;
    for (int i = 1; i < 6; i++) phase_items[i] = 100;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    write_depth(13'd2);
    send_command(build_command(nacc_pkg::OpDeleteSq, 16'h0000, 12'h000, 8'h00, 8'h00,
                               32'h0000_0000));
    send_command(build_command(nacc_pkg::OpCreateSq, 16'hFFFF, 12'hFFF, 8'hFF, 8'hFF,
                               32'hFFFF_FFFF));
    send_command(build_command(nacc_pkg::OpGetLog, 16'h1234, 12'h001, 8'h00, 8'h00,
                               32'h0));
    send_command(build_command(nacc_pkg::OpDeleteCq, 16'h8001, 12'h800, 8'h00, 8'h00,
                               32'h0));
    send_command(build_command(nacc_pkg::OpCreateCq, 16'h7FFE, 12'h7FF, 8'h00, 8'h00,
                               32'h0));
    send_command(build_command(nacc_pkg::OpIdentify, 16'h0101, 12'h010, 8'h01, 8'h00,
                               32'h0));
    send_command(build_command(nacc_pkg::OpIdentify, 16'h0202, 12'h020, 8'h00, 8'h00,
                               32'h0));
    send_command(build_command(nacc_pkg::OpSetFeat, 16'h0303, 12'h030, 8'h00,
                               nacc_pkg::FeatNumQueues, 32'h0000_0000));
    send_command(build_command(nacc_pkg::OpSetFeat, 16'h0404, 12'h040, 8'h00,
                               nacc_pkg::FeatNumQueues, 32'hFFFF_FFFF));
    send_command(build_command(nacc_pkg::OpSetFeat, 16'h0505, 12'h050, 8'h00,
                               nacc_pkg::FeatNumQueues, 32'h003F_003E));
    send_command(build_command(nacc_pkg::OpSetFeat, 16'h0606, 12'h060, 8'h00,
                               nacc_pkg::FeatNumQueues, 32'h0040_0000));
    send_command(build_command(nacc_pkg::OpSetFeat, 16'h0707, 12'h070, 8'h00, FeatOther,
                               32'h0001_0001));
    send_command(build_command(nacc_pkg::OpAsyncEvent, 16'h0808, 12'h080, 8'h00, 8'h00,
                               32'h0));
    send_command(build_command(OpAbort, 16'h0909, 12'h090, 8'h00, 8'h00, 32'h0));
    send_command(build_command(OpGetFeat, 16'h0A0A, 12'h0A0, 8'h00,
                               nacc_pkg::FeatNumQueues, 32'h5));
    send_command(build_command(8'h03, 16'h0B0B, 12'h0B0, 8'h00, 8'h00, 32'h0));
    send_command(build_command(8'hFF, 16'h0C0C, 12'h0C0, 8'h00, 8'h00, 32'h0));
    send_command(build_command(8'h80, 16'h0D0D, 12'h0D0, 8'h00, 8'h00, 32'h0));
    drain();

    for (int p = 0; p < 6; p++) begin
      set_idling(p);
      write_depth(13'(phase_depth[p]));
      repeat (phase_items[p]) send_command(random_command());
      drain();
    end

    if (sb.bad_count == 0 && sb.expected_entries.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nacc_pkg.sv
hw/rtl/nacc_front.sv
hw/rtl/nacc_queue.sv
hw/rtl/nacc_back.sv
hw/rtl/nvme_admin_command_completer.sv
tb/sv/tb.sv
